// ===== design/utf8_to_utf16_decoder_defines.svh =====
// Assertion macros for the UTF-8 to UTF-16 decoder checker.
// Depends on nothing; included by the checker file.
`ifndef UTF8_TO_UTF16_DECODER_DEFINES_SVH
`define UTF8_TO_UTF16_DECODER_DEFINES_SVH

// Concurrent assertion that is switched off while reset is high.
`define U8U16_ASSERT(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Concurrent assertion that also holds across reset.
`define U8U16_ASSERT_ALWAYS(lbl, clk, prop, msg) \
   lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== design/u8u16_pkg.sv =====
// Shared types and constants of the UTF-8 to UTF-16 decoder.
// Used by the front end, the queue, the back end and the top level.
package u8u16_pkg;

   localparam int QueueDepth    = 4;
   localparam int QueueAddrBits = $clog2(QueueDepth);
   localparam int QueueCntBits  = $clog2(QueueDepth + 1);

   localparam logic [15:0] HighSurrogateBase = 16'hD800;
   localparam logic [15:0] LowSurrogateBase  = 16'hDC00;
   localparam logic [31:0] SupplementaryBase = 32'h0001_0000;

   // One decoded transaction handed from the front end to the back end.
   typedef struct packed {
      logic        pair;
      logic [15:0] unit_hi;
      logic [15:0] unit_lo;
      logic        last;
      logic        err;
   } entry_type;

endpackage

// ===== design/u8u16_fifo.sv =====
// Short queue of decoded entries between the front end and the back end.
// Depends on u8u16_pkg for the entry type and the depth.
module u8u16_fifo (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  push,
   input  u8u16_pkg::entry_type  push_data,
   output logic                  full,
   input  logic                  pop,
   output logic                  head_valid,
   output u8u16_pkg::entry_type  head_data
);
   import u8u16_pkg::*;

   entry_type                 slot_ff [QueueDepth];
   logic [QueueAddrBits-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [QueueAddrBits-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [QueueCntBits-1:0]   count_ff, count_in;
   logic                      do_push, do_pop;

   always_comb begin
      full       = (count_ff == QueueCntBits'(QueueDepth));
      head_valid = (count_ff != '0);
      head_data  = slot_ff[rd_ptr_ff];
      do_push    = push && !full;
      do_pop     = pop && head_valid;
      wr_ptr_in  = do_push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in  = do_pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in   = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

// ===== design/u8u16_front.sv =====
// Front end: accepts UTF-8 bytes, tracks the open sequence and builds entries.
// Depends on u8u16_pkg for the entry type and the surrogate constants.
module u8u16_front (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  accept,
   input  logic [7:0]            in_byte,
   input  logic                  in_last,
   output logic                  produce,
   output u8u16_pkg::entry_type  entry
);
   import u8u16_pkg::*;

   logic [1:0]  pending_ff, pending_in;
   logic [1:0]  seq_len_ff, seq_len_in;
   logic [20:0] acc_ff, acc_in;
   logic [20:0] acc_next;
   logic [1:0]  pending_dec;
   logic [31:0] offset;

   always_comb begin
      acc_next    = {acc_ff[14:0], in_byte[5:0]};
      pending_dec = pending_ff - 2'd1;
      offset      = {11'd0, acc_next} - SupplementaryBase;

      produce       = 1'b0;
      entry.pair    = 1'b0;
      entry.unit_hi = '0;
      entry.unit_lo = LowSurrogateBase + {6'd0, acc_next[9:0]};
      entry.last    = in_last;
      entry.err     = 1'b0;
      pending_in    = pending_ff;
      seq_len_in    = seq_len_ff;
      acc_in        = acc_ff;

      if (pending_ff == 2'd0) begin
         if (!in_byte[7]) begin
            produce       = 1'b1;
            entry.unit_hi = {8'd0, in_byte};
         end else begin
            case (in_byte) inside
               [8'h80:8'hDF]: begin
                  acc_in     = {16'd0, in_byte[4:0]};
                  seq_len_in = 2'd1;
               end
               [8'hE0:8'hEF]: begin
                  acc_in     = {17'd0, in_byte[3:0]};
                  seq_len_in = 2'd2;
               end
               default: begin
                  acc_in     = {18'd0, in_byte[2:0]};
                  seq_len_in = 2'd3;
               end
            endcase
            pending_in = seq_len_in;
            if (in_last) begin
               produce    = 1'b1;
               entry.err  = 1'b1;
               pending_in = 2'd0;
               seq_len_in = 2'd0;
               acc_in     = '0;
            end
         end
      end else begin
         acc_in     = acc_next;
         pending_in = pending_dec;
         if (pending_dec != 2'd0) begin
            if (in_last) begin
               produce    = 1'b1;
               entry.err  = 1'b1;
               pending_in = 2'd0;
               seq_len_in = 2'd0;
               acc_in     = '0;
            end
         end else begin
            produce    = 1'b1;
            seq_len_in = 2'd0;
            acc_in     = '0;
            if (seq_len_ff == 2'd3) begin
               entry.pair    = 1'b1;
               entry.unit_hi = HighSurrogateBase + offset[25:10];
            end else begin
               entry.unit_hi = acc_next[15:0];
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pending_ff <= '0;
         seq_len_ff <= '0;
         acc_ff     <= '0;
      end else if (accept) begin
         pending_ff <= pending_in;
         seq_len_ff <= seq_len_in;
         acc_ff     <= acc_in;
      end
   end

endmodule

// ===== design/u8u16_back.sv =====
// Back end: drains queued entries into the output register, one unit per cycle while the receiver is ready.
// Depends on u8u16_pkg for the entry type.
module u8u16_back (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  little_endian,
   input  logic                  head_valid,
   input  u8u16_pkg::entry_type  head_data,
   output logic                  pop,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output logic [15:0]           rsp_unit,
   output logic                  rsp_last,
   output logic                  rsp_err
);
   import u8u16_pkg::*;

   logic        valid_ff, valid_in;
   logic        phase_ff, phase_in;
   logic [15:0] unit_ff, unit_in;
   logic        last_ff, last_in;
   logic        err_ff, err_in;
   logic        load, first_half;
   logic [15:0] unit_sel;

   always_comb begin
      load       = (!valid_ff || rsp_ready) && head_valid;
      first_half = head_data.pair && !phase_ff;
      pop        = load && !first_half;
      unit_sel   = (head_data.pair && phase_ff) ? head_data.unit_lo : head_data.unit_hi;
      unit_in    = little_endian ? unit_sel : {unit_sel[7:0], unit_sel[15:8]};
      last_in    = first_half ? 1'b0 : head_data.last;
      err_in     = first_half ? 1'b0 : head_data.err;
      valid_in   = valid_ff && !rsp_ready;
      phase_in   = phase_ff;
      if (load) begin
         valid_in = 1'b1;
         phase_in = first_half;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         phase_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
         phase_ff <= phase_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         unit_ff <= unit_in;
         last_ff <= last_in;
         err_ff  <= err_in;
      end
   end

   assign rsp_valid = valid_ff;
   assign rsp_unit  = unit_ff;
   assign rsp_last  = last_ff;
   assign rsp_err   = err_ff;

endmodule

// ===== design/utf8_to_utf16_decoder.sv =====
// UTF-8 to UTF-16 decoder, top level.
// Depends on u8u16_pkg, u8u16_front, u8u16_fifo and u8u16_back.
//
// Usage:
// The req_ channel carries one UTF-8 byte per transaction in req_tdata, with
// req_tlast high on the final byte of a string. The rsp_ channel returns
// UTF-16 code units in rsp_tdata, rsp_tlast marks the final unit of the
// string, and rsp_tuser flags a string that ended inside a sequence; such a
// transaction carries a zero unit and the consumer drops the whole string.
// A four-byte sequence gives a surrogate pair as two transactions.
// The block takes one byte per cycle while the queue is not full. A unit
// reaches rsp_ by way of a four-entry queue, into which the front end decodes
// the completing byte combinationally, and then the output register, which
// loads from the queue head. Output runs at one unit per cycle while the
// receiver is ready, so a pair leaves as two units from its four input bytes.
// When the receiver stalls, the output register holds and the queue fills;
// req_tready falls only once the queue is full.
// Reset clears the queue, the open sequence and the output, and sets
// little-endian order. csr_wr_en writes the byte order bit; write it only
// while no string is in flight.
module utf8_to_utf16_decoder (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] in_byte
   input  logic        req_tlast,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [15:0] rsp_tdata,   // [15:0] code_unit
   output logic        rsp_tlast,
   output logic [0:0]  rsp_tuser,   // [0] truncated_error
   input  logic        csr_wr_en,
   input  logic        csr_wr_data
);
   import u8u16_pkg::*;

   logic      little_endian_ff;
   logic      accept, produce, full, pop, head_valid;
   entry_type entry, head_data;

   always_ff @(posedge clock) begin
      if (reset) begin
         little_endian_ff <= 1'b1;
      end else if (csr_wr_en) begin
         little_endian_ff <= csr_wr_data;
      end
   end

   assign req_tready = !full;
   assign accept     = req_tvalid && req_tready;

   u8u16_front u_front (
      .clock   (clock),
      .reset   (reset),
      .accept  (accept),
      .in_byte (req_tdata),
      .in_last (req_tlast),
      .produce (produce),
      .entry   (entry)
   );

   u8u16_fifo u_fifo (
      .clock      (clock),
      .reset      (reset),
      .push       (accept && produce),
      .push_data  (entry),
      .full       (full),
      .pop        (pop),
      .head_valid (head_valid),
      .head_data  (head_data)
   );

   u8u16_back u_back (
      .clock         (clock),
      .reset         (reset),
      .little_endian (little_endian_ff),
      .head_valid    (head_valid),
      .head_data     (head_data),
      .pop           (pop),
      .rsp_valid     (rsp_tvalid),
      .rsp_ready     (rsp_tready),
      .rsp_unit      (rsp_tdata),
      .rsp_last      (rsp_tlast),
      .rsp_err       (rsp_tuser[0])
   );

endmodule

// ===== design/u8u16_checker.sv =====
// Port-level checker for the UTF-8 to UTF-16 decoder, bound to the top level.
// Depends on utf8_to_utf16_decoder_defines.svh for the assertion macros.
`include "utf8_to_utf16_decoder_defines.svh"

module u8u16_checker (
   input logic        clock,
   input logic        reset,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [15:0] rsp_tdata,
   input logic        rsp_tlast,
   input logic [0:0]  rsp_tuser
);

   `U8U16_ASSERT(a_rsp_valid_holds, clock, reset,
      rsp_tvalid && !rsp_tready |=> rsp_tvalid,
      "rsp_tvalid dropped while stalled")
   `U8U16_ASSERT(a_rsp_payload_holds, clock, reset,
      rsp_tvalid && !rsp_tready |=>
         $stable(rsp_tdata) && $stable(rsp_tlast) && $stable(rsp_tuser),
      "rsp payload changed while stalled")
   `U8U16_ASSERT(a_error_closes_string, clock, reset,
      rsp_tvalid && rsp_tuser[0] |-> rsp_tlast && rsp_tdata == 16'h0000,
      "truncation transaction must be last with a zero unit")
   `U8U16_ASSERT_ALWAYS(a_reset_clears_output, clock,
      reset |=> !rsp_tvalid,
      "rsp_tvalid high right after reset")

endmodule

bind utf8_to_utf16_decoder u8u16_checker u_checker (.*);
